// ===== rtl/bsdl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, operation codes and result types for the bounded sorted deque list.
// Depends on nothing; every other file in rtl/ except bsdl_ram imports it.
package bsdl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 5;

    localparam int S_FIELDS_W = OP_W + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + VAL_W + COUNT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_SORTED_INS = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_REMOVE_VAL = 3'd5,
        OP_CLEAR      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_INS,
        MODE_REM
    } mode_t;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] removed_value;
        logic [COUNT_W-1:0] count;
        logic             empty_res;
    } res_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] cnt;
    } stat_t;

endpackage

// ===== rtl/bsdl_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bsdl_cmp.sv =====
`timescale 1ns / 1ps
// Shared compare unit: decides whether the entry just read is the insert/remove point.
// Depends on bsdl_pkg.
module bsdl_cmp (
    input  bsdl_pkg::op_t                   op,
    input  logic [bsdl_pkg::VAL_W-1:0]      data,
    input  logic [bsdl_pkg::VAL_W-1:0]      value,
    output logic                            hit
);
    import bsdl_pkg::*;

    logic lt;
    logic eq;

    assign lt = $signed(data) < $signed(value);
    assign eq = (data == value);

    always_comb
    begin
        case (op)
            OP_PUSH_FRONT: hit = 1'b1;
            OP_POP_FRONT:  hit = 1'b1;
            OP_POP_BACK:   hit = 1'b1;
            OP_SORTED_INS: hit = lt;
            OP_REMOVE_VAL: hit = eq;
            default:       hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/bsdl_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: walks the entry RAM one position per cycle, rippling entries up
// (insert) or down (remove). Depends on bsdl_pkg; drives bsdl_ram, reads bsdl_cmp.
module bsdl_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bsdl_pkg::op_t                 in_op,
    input  logic [bsdl_pkg::VAL_W-1:0]    in_value,
    input  logic                          out_free,
    output logic                          done,
    output bsdl_pkg::res_t                res,
    output bsdl_pkg::stat_t               stat,
    output bsdl_pkg::op_t                 cur_op,
    output logic [bsdl_pkg::VAL_W-1:0]    cur_value,
    input  logic                          hit,
    output logic                          ram_we,
    output logic [bsdl_pkg::IDX_W-1:0]    ram_waddr,
    output logic [bsdl_pkg::VAL_W-1:0]    ram_wdata,
    output logic [bsdl_pkg::IDX_W-1:0]    ram_raddr,
    input  logic [bsdl_pkg::VAL_W-1:0]    ram_rdata
);
    import bsdl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg,   state_next;
    op_t              op_reg,      op_next;
    mode_t            mode_reg,    mode_next;
    logic [VAL_W-1:0] val_reg,     val_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [CNT_W-1:0] rd_idx_reg,  rd_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             found_reg,   found_next;
    logic             nok_reg,     nok_next;
    logic [VAL_W-1:0] carry_reg,   carry_next;
    logic [VAL_W-1:0] rem_reg,     rem_next;

    logic             issue;
    logic             finish;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] new_cnt;

    assign full   = (cnt_reg == CNT_W'(CAPACITY));
    assign empty  = (cnt_reg == '0);
    assign issue  = (state_reg == ST_RUN) && (rd_idx_reg < cnt_reg);
    assign finish = (state_reg == ST_RUN) && !issue && !cmp_vld_reg && out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign done      = finish;
    assign cur_op    = op_reg;
    assign cur_value = val_reg;
    assign ram_raddr = rd_idx_reg[IDX_W-1:0];
    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.cnt  = cnt_reg;

    // count after the operation finishes
    always_comb
    begin
        case (mode_reg)
            MODE_INS: new_cnt = cnt_reg + CNT_W'(1);
            MODE_REM: new_cnt = found_reg ? cnt_reg - CNT_W'(1) : cnt_reg;
            default:  new_cnt = cnt_reg;
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_INS: res.ok = 1'b1;
            MODE_REM: res.ok = found_reg;
            default:  res.ok = nok_reg;
        endcase
        res.removed_value = (mode_reg == MODE_REM && found_reg) ? rem_reg : '0;
        res.count         = COUNT_W'(new_cnt);
        res.empty_res     = (new_cnt == '0);
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        mode_next    = mode_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        found_next   = found_reg;
        nok_next     = nok_reg;
        carry_next   = carry_reg;
        rem_next     = rem_reg;
        ram_we       = 1'b0;
        ram_waddr    = cmp_idx_reg;
        ram_wdata    = carry_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = ST_RUN;
                    op_next      = in_op;
                    val_next     = in_value;
                    found_next   = 1'b0;
                    cmp_vld_next = 1'b0;
                    nok_next     = 1'b0;
                    mode_next    = MODE_NONE;
                    rd_idx_next  = cnt_reg;
                    case (in_op)
                        OP_PUSH_FRONT, OP_SORTED_INS:
                        begin
                            if (!full)
                            begin
                                mode_next   = MODE_INS;
                                rd_idx_next = '0;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (!full)
                            begin
                                mode_next = MODE_INS;
                            end
                        end
                        OP_POP_FRONT, OP_REMOVE_VAL:
                        begin
                            if (!empty)
                            begin
                                mode_next   = MODE_REM;
                                rd_idx_next = '0;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (!empty)
                            begin
                                mode_next   = MODE_REM;
                                rd_idx_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            nok_next    = 1'b1;
                            cnt_next    = '0;
                            rd_idx_next = '0;
                        end
                        default:
                        begin
                            nok_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                cmp_vld_next = issue;
                cmp_idx_next = rd_idx_reg[IDX_W-1:0];

                if (cmp_vld_reg)
                begin
                    case (mode_reg)
                        MODE_INS:
                        begin
                            if (found_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = carry_reg;
                                carry_next = ram_rdata;
                            end
                            else if (hit)
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = val_reg;
                                carry_next = ram_rdata;
                                found_next = 1'b1;
                            end
                        end
                        MODE_REM:
                        begin
                            if (found_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cmp_idx_reg - IDX_W'(1);
                                ram_wdata = ram_rdata;
                            end
                            else if (hit)
                            begin
                                rem_next   = ram_rdata;
                                found_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            ram_we = 1'b0;
                        end
                    endcase
                end

                if (finish)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = new_cnt;
                    if (mode_reg == MODE_INS)
                    begin
                        // tail write: displaced entry, or the new value at the back
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[IDX_W-1:0];
                        ram_wdata = found_reg ? carry_reg : val_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_CLEAR;
            mode_reg    <= MODE_NONE;
            val_reg     <= '0;
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            nok_reg     <= 1'b0;
            carry_reg   <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            mode_reg    <= mode_next;
            val_reg     <= val_next;
            cnt_reg     <= cnt_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_idx_reg <= cmp_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            nok_reg     <= nok_next;
            carry_reg   <= carry_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

// ===== rtl/bounded_sorted_deque_list.sv =====
`timescale 1ns / 1ps
// Top level of the bounded sorted deque list: stream ports, result register, assertions.
// Depends on bsdl_pkg, bsdl_ram, bsdl_cmp and bsdl_ctrl.
//
// Usage
//   s_* channel: one transaction per operation (push front/back, sorted insert,
//   pop front/back, remove by value, clear). m_* channel: one result transaction
//   per operation with ok, removed value, count and empty flag.
//   Entries live in a CAPACITY-deep RAM, front at address 0. A single pass walks
//   the RAM one address per cycle through one compare unit; inserts ripple the
//   entries behind the insert point up by one, removals ripple them down.
// Pass length
//   Each operation reads N entries in its pass: every entry for push front, sorted
//   insert, pop front and remove by value; one for pop back; none for push back,
//   clear and rejected operations. N is at most CAPACITY. The next operation is
//   accepted only after the current one has finished.
//   s_tready drops for the whole operation; the RAM read port sets the pace.
// Reset
//   rst_n clears the sequencer and the entry count; RAM contents are left as is
//   and are never read before being written.
// Stall
//   The result sits in an output register; the next operation is accepted while
//   it waits. A finished operation holds in the sequencer until that register is
//   free, so nothing is lost or overwritten.
module bounded_sorted_deque_list (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bsdl_pkg::S_TDATA_W-1:0] s_tdata,  // [2:0] operation, [34:3] value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bsdl_pkg::M_TDATA_W-1:0] m_tdata   // [0] ok, [32:1] removed_value,
                                                     // [37:33] count, [38] empty_res
);
    import bsdl_pkg::*;

    op_t              in_op;
    logic [VAL_W-1:0] in_value;
    op_t              cur_op;
    logic [VAL_W-1:0] cur_value;
    logic             hit;
    logic             done;
    res_t             res;
    stat_t            stat;
    logic             out_free;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    logic             m_valid_reg, m_valid_next;
    res_t             m_res_reg,   m_res_next;

    assign in_op    = op_t'(s_tdata[OP_W-1:0]);
    assign in_value = s_tdata[OP_W +: VAL_W];
    assign out_free = !m_valid_reg || m_tready;

    bsdl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bsdl_cmp u_cmp (
        .op    (cur_op),
        .data  (ram_rdata),
        .value (cur_value),
        .hit   (hit)
    );

    bsdl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (in_op),
        .in_value  (in_value),
        .out_free  (out_free),
        .done      (done),
        .res       (res),
        .stat      (stat),
        .cur_op    (cur_op),
        .cur_value (cur_value),
        .hit       (hit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // result register: load on completion, drop once taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (done)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_res_reg   <= '0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            m_res_reg   <= m_res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_res_reg.empty_res, m_res_reg.count,
                       m_res_reg.removed_value, m_res_reg.ok};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.cnt <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!s_tready && stat.busy))
        else $error("sequencer ready right after accepting a transaction");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_res_reg.empty_res == (m_res_reg.count == '0)))
        else $error("empty flag disagrees with count");

    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_res_reg.ok) |-> (m_res_reg.removed_value == '0))
        else $error("failed operation reports a removed value");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_free)
        else $error("result completed into an occupied output register");

endmodule
